[rtl/b2da_pkg.sv]
package b2da_pkg;

    localparam int VALUE_WIDTH = 64;
    // Decimal digits needed for the largest unsigned value at VALUE_WIDTH bits
    localparam int DIGITS      = 20;
    localparam int DIG_W       = 4;
    localparam int BCD_W       = DIGITS * DIG_W;
    localparam int IDX_W       = $clog2(DIGITS);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int CHAR_W      = 6;
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef enum logic [1:0] {
        CNV_IDLE,
        CNV_SHIFT,
        CNV_DONE
    } cnv_state_t;

    // Finished conversion handed from the converter to the character emitter
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [IDX_W-1:0] top_idx;
        logic [BCD_W-1:0] bcd;
    } cnv_result_t;

    function automatic logic [DIG_W-1:0] add3(input logic [DIG_W-1:0] d);
        logic [DIG_W-1:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

[rtl/binary_to_decimal_ascii.sv]
// Binary to decimal ASCII converter.
// Slave channel: s_tdata carries the 64-bit integer, s_tuser is set to read it
// as two's complement. A request is taken when s_tvalid and s_tready are high.
// Master channel: one character per transfer, most significant first; '-' leads
// a negative signed value, zero gives a single '0', m_tlast marks the final
// character of each number.
// A request passes the converter's SHIFT and DONE states, then the emitter's
// busy and output registers, before its first character is on m_tvalid. The
// shift-and-add-3 converter runs one bit per cycle; its finished digits move
// to the emitter, which sends one character per cycle from its output register
// whenever m_tready is high; meanwhile the converter already takes the next
// request. A number has at most 20 characters.
// When m_tready is low the output register holds its character, the emitter
// waits, and once the converter has a finished number queued s_tready stays
// low. Reset (aresetn low) drops all work in flight and clears m_tvalid.
module binary_to_decimal_ascii (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [b2da_pkg::TDATA_IN_W-1:0]        s_tdata,   // [63:0] value_bits
    input  logic                                   s_tuser,   // [0] is_signed
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [b2da_pkg::TDATA_OUT_W-1:0]       m_tdata,   // [5:0] char_code, [7:6] zero
    output logic                                   m_tlast    // last_char
);

    b2da_pkg::cnv_result_t cnv_res;
    logic                  cnv_take;

    b2da_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[b2da_pkg::VALUE_WIDTH-1:0]),
        .in_signed (s_tuser),
        .res       (cnv_res),
        .res_take  (cnv_take)
    );

    b2da_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (cnv_res),
        .res_take (cnv_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/b2da_dabble.sv]
module b2da_dabble (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [b2da_pkg::VALUE_WIDTH-1:0]       in_value,
    input  logic                                   in_signed,
    output b2da_pkg::cnv_result_t                  res,
    input  logic                                   res_take
);

    b2da_pkg::cnv_state_t                   state_reg, state_next;
    logic [b2da_pkg::VALUE_WIDTH-1:0]       bin_reg, bin_next;
    logic [b2da_pkg::BCD_W-1:0]             bcd_reg, bcd_next;
    logic [b2da_pkg::CNT_W-1:0]             cnt_reg, cnt_next;
    logic [b2da_pkg::IDX_W-1:0]             top_reg, top_next;
    logic                                   neg_reg, neg_next;

    logic                                   in_neg;
    logic [b2da_pkg::VALUE_WIDTH-1:0]       in_mag;
    logic [b2da_pkg::BCD_W-1:0]             bcd_adj;
    logic [b2da_pkg::BCD_W-1:0]             bcd_shift;
    logic                                   grow;

    assign in_neg = in_signed & in_value[b2da_pkg::VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

    // Add 3 to every digit of 5 or more, then shift one binary bit in
    always_comb begin
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            bcd_adj[i*b2da_pkg::DIG_W +: b2da_pkg::DIG_W] =
                b2da_pkg::add3(bcd_reg[i*b2da_pkg::DIG_W +: b2da_pkg::DIG_W]);
        end
    end

    assign bcd_shift = {bcd_adj[b2da_pkg::BCD_W-2:0], bin_reg[b2da_pkg::VALUE_WIDTH-1]};

    // One shift grows the number by at most one digit: check just above the top
    always_comb begin
        grow = 1'b0;
        for (int i = 1; i < b2da_pkg::DIGITS; i++) begin
            if ((b2da_pkg::IDX_W'(i) == top_reg + 1'b1) &&
                (bcd_shift[i*b2da_pkg::DIG_W +: b2da_pkg::DIG_W] != '0)) begin
                grow = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            b2da_pkg::CNV_IDLE: begin
                if (in_valid) state_next = b2da_pkg::CNV_SHIFT;
            end
            b2da_pkg::CNV_SHIFT: begin
                if (cnt_reg == '0) state_next = b2da_pkg::CNV_DONE;
            end
            b2da_pkg::CNV_DONE: begin
                if (res_take) state_next = b2da_pkg::CNV_IDLE;
            end
            default: state_next = b2da_pkg::CNV_IDLE;
        endcase
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        top_next = top_reg;
        neg_next = neg_reg;
        unique case (state_reg)
            b2da_pkg::CNV_IDLE: begin
                if (in_valid) begin
                    bin_next = in_mag;
                    bcd_next = '0;
                    cnt_next = b2da_pkg::CNT_W'(b2da_pkg::VALUE_WIDTH - 1);
                    top_next = '0;
                    neg_next = in_neg;
                end
            end
            b2da_pkg::CNV_SHIFT: begin
                bin_next = {bin_reg[b2da_pkg::VALUE_WIDTH-2:0], 1'b0};
                bcd_next = bcd_shift;
                cnt_next = cnt_reg - 1'b1;
                if (grow) top_next = top_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        in_ready      = (state_reg == b2da_pkg::CNV_IDLE);
        res.valid     = (state_reg == b2da_pkg::CNV_DONE);
        res.neg       = neg_reg;
        res.top_idx   = top_reg;
        res.bcd       = bcd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= b2da_pkg::CNV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        top_reg <= top_next;
        neg_reg <= neg_next;
    end

endmodule

[rtl/b2da_emit.sv]
module b2da_emit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  b2da_pkg::cnv_result_t                  res,
    output logic                                   res_take,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [b2da_pkg::TDATA_OUT_W-1:0]       m_tdata,
    output logic                                   m_tlast
);

    logic                                   busy_reg, busy_next;
    logic                                   minus_reg, minus_next;
    logic [b2da_pkg::IDX_W-1:0]             idx_reg, idx_next;
    logic [b2da_pkg::BCD_W-1:0]             bcd_reg, bcd_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]            out_char_reg, out_char_next;
    logic                                   out_last_reg, out_last_next;

    logic                                   advance;
    logic [b2da_pkg::DIG_W-1:0]             digit;

    assign advance  = !out_valid_reg || m_tready;
    assign res_take = !busy_reg && res.valid;

    always_comb begin
        digit = '0;
        for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
            if (b2da_pkg::IDX_W'(i) == idx_reg) begin
                digit = bcd_reg[i*b2da_pkg::DIG_W +: b2da_pkg::DIG_W];
            end
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        minus_next     = minus_reg;
        idx_next       = idx_reg;
        bcd_next       = bcd_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (res_take) begin
            busy_next  = 1'b1;
            minus_next = res.neg;
            idx_next   = res.top_idx;
            bcd_next   = res.bcd;
        end
        if (advance) begin
            out_valid_next = busy_reg;
            if (busy_reg) begin
                if (minus_reg) begin
                    out_char_next = b2da_pkg::CHAR_MINUS;
                    out_last_next = 1'b0;
                    minus_next    = 1'b0;
                end else begin
                    out_char_next = b2da_pkg::CHAR_ZERO + {2'b00, digit};
                    out_last_next = (idx_reg == '0);
                    // drop to idle after the units digit
                    if (idx_reg == '0) begin
                        busy_next = 1'b0;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_char_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        minus_reg    <= minus_next;
        idx_reg      <= idx_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

[sim/b2da_text_checker.sv]
`timescale 1ns / 1ps

module b2da_text_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [b2da_pkg::TDATA_IN_W-1:0]    s_tdata,   // [63:0] value_bits
    input  logic                               s_tuser,   // [0] is_signed
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [b2da_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [5:0] char_code, [7:6] zero
    input  logic                               m_tlast,
    output int                                 errors,
    output int                                 pending,
    output int                                 numbers_seen,
    output int                                 negatives_seen,
    output int                                 chars_checked
);

    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] code;
        logic                        last;
    } text_char_t;

    text_char_t expected_text[$];

    initial begin
        errors         = 0;
        pending        = 0;
        numbers_seen   = 0;
        negatives_seen = 0;
        chars_checked  = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40)
            $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    // Queue the decimal characters of one request, sign first, most significant digit next.
    function automatic logic predict_decimal_text(input logic [63:0] raw, input logic sgn);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digs[20];
        int          nd;
        text_char_t  c;
        mask = {64{1'b1}} >> (64 - b2da_pkg::VALUE_WIDTH);
        v    = raw & mask;
        neg  = sgn && v[b2da_pkg::VALUE_WIDTH-1];
        mag  = neg ? ((~v + 64'd1) & mask) : v;
        nd   = 0;
        do begin
            digs[nd] = 4'(mag % 64'd10);
            mag      = mag / 64'd10;
            nd++;
        end while (mag != 0 && nd < 20);
        if (neg) begin
            c.code = b2da_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.code = b2da_pkg::CHAR_ZERO + b2da_pkg::CHAR_W'(digs[k]);
            c.last = (k == 0);
            expected_text.push_back(c);
        end
        return neg;
    endfunction

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                numbers_seen <= numbers_seen + 1;
                if (predict_decimal_text(s_tdata, s_tuser))
                    negatives_seen <= negatives_seen + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch("unexpected character",
                                    m_tdata[b2da_pkg::CHAR_W-1:0], -1);
                end else begin
                    want = expected_text.pop_front();
                    chars_checked <= chars_checked + 1;
                    if (m_tdata[b2da_pkg::CHAR_W-1:0] !== want.code)
                        report_mismatch("char_code", m_tdata[b2da_pkg::CHAR_W-1:0],
                                        want.code);
                    if (m_tlast !== want.last)
                        report_mismatch("last_char", m_tlast, want.last);
                end
            end
            pending <= expected_text.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    logic                                 aclk     = 1'b0;
    logic                                 aresetn  = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [b2da_pkg::TDATA_IN_W-1:0]      s_tdata  = '0;   // [63:0] value_bits
    logic                                 s_tuser  = 1'b0; // [0] is_signed
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [b2da_pkg::TDATA_OUT_W-1:0]     m_tdata;         // [5:0] char_code, [7:6] zero
    logic                                 m_tlast;

    int errors, pending, numbers_seen, negatives_seen, chars_checked;
    logic        no_idle = 1'b0;
    int unsigned rx_hold = 0;
    int unsigned rx_roll;

    binary_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    b2da_text_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .errors         (errors),
        .pending        (pending),
        .numbers_seen   (numbers_seen),
        .negatives_seen (negatives_seen),
        .chars_checked  (chars_checked)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(100_000_000);
        $display("testbench: errors");
        $finish;
    end

    // Receiver: mostly ready, short stalls now and then, rare long ones.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 10) begin
                rx_hold = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else if (rx_roll < 12) begin
                rx_hold = $urandom_range(20, 200);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic int idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] off;
        off = 64'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 999));
            2: return pow10($urandom_range(0, 19)) + off - 64'd1;
            3: return -64'($urandom_range(1, 1000));
            4: return {$urandom, $urandom} % pow10($urandom_range(1, 19));
            default: begin
                case ($urandom_range(0, 2))
                    0: return (64'd1 << 63) + off;
                    1: return (64'd1 << 63) - off - 64'd1;
                    default: return {64{1'b1}} - off;
                endcase
            end
        endcase
    endfunction

    // Present one request and hold it until the converter takes it.
    task automatic send_number(input logic [63:0] value, input logic sgn);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= sgn;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        int drain;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_number(64'd0, 1'b0);
        send_number(64'd0, 1'b1);
        send_number(64'd1, 1'b0);
        send_number(64'd9, 1'b1);
        send_number(64'd10, 1'b0);
        send_number(64'd99, 1'b0);
        send_number(64'd100, 1'b1);
        send_number(64'd999, 1'b0);
        send_number(64'd1000, 1'b0);
        send_number({64{1'b1}}, 1'b0);          // largest unsigned, 20 digits
        send_number({64{1'b1}}, 1'b1);          // minus one
        send_number(64'd1 << 63, 1'b1);         // most negative, 19 digits and sign
        send_number(64'd1 << 63, 1'b0);
        send_number((64'd1 << 63) - 64'd1, 1'b1);
        send_number((64'd1 << 63) - 64'd1, 1'b0);
        send_number((64'd1 << 63) + 64'd1, 1'b1);
        send_number(pow10(19), 1'b0);
        send_number(pow10(19) - 64'd1, 1'b0);
        send_number(pow10(18), 1'b1);
        send_number(pow10(18) - 64'd1, 1'b1);
        send_number(-64'd10, 1'b1);
        send_number(-64'd10, 1'b0);
        send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_number(64'h5555_5555_5555_5555, 1'b1);

        // back-to-back stretch, the receiver ready once any held stall runs out
        no_idle <= 1'b1;
        for (int i = 0; i < 80; i++)
            send_number(random_value(), 1'($urandom_range(0, 1)));
        no_idle <= 1'b0;
        for (int i = 0; i < 276; i++)
            send_number(random_value(), 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        for (drain = 0; drain < 100; drain++) @(posedge aclk);

        $display("converted %0d numbers (%0d negative), %0d characters compared",
                 numbers_seen, negatives_seen, chars_checked);
        $display("covered zero, digit-count boundaries, both 64-bit extremes, random stalls");
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
